// ----- hw/rtl/dcg_pkg.sv -----
// Shared types, constants and the raised-cosine ROM of the curve CV and gate generator.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package dcg_pkg;

    // Table sizes; both depths are powers of two.
    localparam int TABLE_DEPTH = 2048;
    localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PHASE_BITS = 32;
    localparam int COS_DEPTH = 256;
    localparam int COS_ADDR_W = $clog2(COS_DEPTH);
    localparam int COS_SPAN = COS_DEPTH - 1;

    // Field widths
    localparam int STEP_W = 32;
    localparam int DIR_W = 2;
    localparam int RAMP_W = 12;
    localparam int RECIP_W = 17;
    localparam int COEFF_W = 16;
    localparam int INDEX_W = 11;
    localparam int VALUE_W = 16;
    localparam int ENTRY_W = VALUE_W + 1;
    localparam int SMOOTH_W = 24;
    localparam int USED_W = RAMP_W + RECIP_W;
    localparam int PROG_W = 17;
    localparam int RI_PROD_W = PROG_W + COS_ADDR_W + 1;
    localparam int SMOOTH_PROD_W = COEFF_W + SMOOTH_W;
    localparam int CV_SUM_W = SMOOTH_W + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Queue sizes; depths are powers of two.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = RESQ_PTR_W + 1;
    // Results queued plus ticks still in the back end pipeline
    localparam int RESQ_PEND_W = RESQ_CNT_W + 1;

    localparam logic [VALUE_W-1:0] FULL_SCALE = 16'd32768;
    localparam logic [ENTRY_W-1:0] HOLE_WORD = {1'b1, {VALUE_W{1'b0}}};
    localparam int HOLE_BIT = VALUE_W;
    localparam int ONE_Q16 = 65536;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_FROZEN = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

    // Reset values of the registers
    localparam logic [STEP_W-1:0] RST_PHASE_STEP = 32'd24348;
    localparam logic [DIR_W-1:0] RST_DIRECTION = DIR_FORWARD;
    localparam logic [RAMP_W-1:0] RST_DECLICK_LENGTH = 12'd64;
    localparam logic [RECIP_W-1:0] RST_DECLICK_RECIP = 17'd1024;
    localparam logic [COEFF_W-1:0] RST_SMOOTHING_COEFF = 16'd370;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP      = 3'd0,
        CFG_DIRECTION       = 3'd1,
        CFG_DECLICK_LENGTH  = 3'd2,
        CFG_DECLICK_RECIP   = 3'd3,
        CFG_SMOOTHING_COEFF = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef logic [TABLE_ADDR_W-1:0] addr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [DIR_W-1:0]   direction;
        logic [RAMP_W-1:0]  declick_length;
        logic [RECIP_W-1:0] declick_reciprocal;
        logic [COEFF_W-1:0] smoothing_coeff;
    } cfg_t;

    typedef struct packed {
        op_t    op;
        logic   lock;
        addr_t  addr;
        entry_t data;
    } cmd_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] cv;
        logic [VALUE_W-1:0] gate;
        logic [INDEX_W-1:0] scan_index;
    } result_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Raised-cosine ROM, built at elaboration from a Taylor series in Q28.
    localparam longint ONE_Q28 = 64'sd268435456;
    localparam logic [63:0] PI_Q28 = 64'd843314857;
    localparam logic [63:0] COS_SPAN_WIDE = 64'(COS_SPAN);

    typedef logic [VALUE_W-1:0] cos_rom_t [COS_DEPTH];

    function automatic longint cos_q28(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint sum;
        x2 = (x * x) >> 28;
        term = 64'(ONE_Q28);
        sum = ONE_Q28;
        term = ((term * x2) >> 28) / 64'd2;   sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 64'd12;  sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 64'd30;  sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 64'd56;  sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 64'd90;  sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 64'd132; sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 64'd182; sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 64'd240; sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 64'd306; sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 64'd380; sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 64'd462; sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 64'd552; sum = sum + longint'(term);
        return sum;
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        logic [63:0] x;
        longint v;
        for (int k = 0; k < COS_DEPTH; k++) begin
            x = (PI_Q28 * 64'(k) + (COS_SPAN_WIDE >> 1)) / COS_SPAN_WIDE;
            v = (ONE_Q28 - cos_q28(x) + 64'sd8192) / 64'sd16384;
            if (v < 64'sd0) begin
                v = 64'sd0;
            end
            if (v > 64'sd32768) begin
                v = 64'sd32768;
            end
            rom[k] = VALUE_W'(v);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

// ----- hw/rtl/drawn_curve_cv_gate_generator.sv -----
// Top level of the drawn-curve CV and gate generator: register file, front end, command
// queue, back end and result queue. Depends on dcg_pkg and all dcg_* modules.
`default_nettype none

// Each tick beat scans a 2048-entry curve table with a phase accumulator and yields one
// result (smoothed CV, declicked gate, entry index); a table-write beat yields none. Write
// beats are taken one per cycle while full is low; a tick beat waits until the previous
// tick has left stage 1, since the smoothing loop's difference and coefficient multiply-
// accumulate take two stages before the next tick may read the smoothed value. After reset
// a clearing pass marks all 2048 curve entries as holes, one per cycle; full stays high
// until it ends, while register writes are taken as usual. The user must write registers
// only while the block is idle; the block itself does not enforce this.
module drawn_curve_cv_gate_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            command,
    input  wire logic                            write_lock,
    input  wire logic [dcg_pkg::INDEX_W-1:0]     table_index,
    input  wire logic [dcg_pkg::VALUE_W-1:0]     table_value,
    input  wire logic                            table_hole,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [dcg_pkg::VALUE_W-1:0]          cv,
    output logic [dcg_pkg::VALUE_W-1:0]          gate,
    output logic [dcg_pkg::INDEX_W-1:0]          scan_index,
    input  wire logic                            cfg_write,
    input  wire logic [dcg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dcg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dcg_pkg::cfg_t                  cfg_reg;
    dcg_pkg::cfg_t                  cfg_next;
    dcg_pkg::back_status_t          back_status;
    dcg_pkg::cmd_item_t             front_item;
    dcg_pkg::cmd_item_t             back_item;
    dcg_pkg::result_t               res_in;
    dcg_pkg::result_t               res_head;
    logic                           front_push;
    logic                           cmdq_full;
    logic                           cmdq_valid;
    logic                           cmdq_pop;
    logic                           res_push;
    logic [dcg_pkg::RESQ_CNT_W-1:0] res_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dcg_pkg::CFG_PHASE_STEP:
                    cfg_next.phase_step = cfg_data[dcg_pkg::STEP_W-1:0];
                dcg_pkg::CFG_DIRECTION:
                    cfg_next.direction = cfg_data[dcg_pkg::DIR_W-1:0];
                dcg_pkg::CFG_DECLICK_LENGTH:
                    cfg_next.declick_length = cfg_data[dcg_pkg::RAMP_W-1:0];
                dcg_pkg::CFG_DECLICK_RECIP:
                    cfg_next.declick_reciprocal = cfg_data[dcg_pkg::RECIP_W-1:0];
                dcg_pkg::CFG_SMOOTHING_COEFF:
                    cfg_next.smoothing_coeff = cfg_data[dcg_pkg::COEFF_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= dcg_pkg::RST_PHASE_STEP;
            cfg_reg.direction <= dcg_pkg::RST_DIRECTION;
            cfg_reg.declick_length <= dcg_pkg::RST_DECLICK_LENGTH;
            cfg_reg.declick_reciprocal <= dcg_pkg::RST_DECLICK_RECIP;
            cfg_reg.smoothing_coeff <= dcg_pkg::RST_SMOOTHING_COEFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dcg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .write_lock  (write_lock),
        .table_index (table_index),
        .table_value (table_value),
        .table_hole  (table_hole),
        .cfg         (cfg_reg),
        .back_status (back_status),
        .q_full      (cmdq_full),
        .q_push      (front_push),
        .q_item      (front_item)
    );

    dcg_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .item_in  (front_item),
        .full     (cmdq_full),
        .valid    (cmdq_valid),
        .item_out (back_item),
        .pop      (cmdq_pop)
    );

    dcg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .status    (back_status),
        .q_valid   (cmdq_valid),
        .q_item    (back_item),
        .q_pop     (cmdq_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_item  (res_in)
    );

    dcg_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .item_in (res_in),
        .count   (res_count),
        .empty   (empty),
        .head    (res_head),
        .pop     (pop)
    );

    assign cv = res_head.cv;
    assign gate = res_head.gate;
    assign scan_index = res_head.scan_index;

endmodule

`default_nettype wire

// ----- hw/rtl/dcg_front.sv -----
// Front end: takes input beats, keeps the phase accumulator and turns each beat into a
// memory command for the back end. Depends on dcg_pkg.
`default_nettype none

module dcg_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          command,
    input  wire logic                          write_lock,
    input  wire logic [dcg_pkg::INDEX_W-1:0]   table_index,
    input  wire logic [dcg_pkg::VALUE_W-1:0]   table_value,
    input  wire logic                          table_hole,
    input  wire dcg_pkg::cfg_t                 cfg,
    input  wire dcg_pkg::back_status_t         back_status,
    input  wire logic                          q_full,
    output logic                               q_push,
    output dcg_pkg::cmd_item_t                 q_item
);

    logic [dcg_pkg::PHASE_BITS-1:0] phase_reg;
    logic [dcg_pkg::PHASE_BITS-1:0] phase_next;
    logic [dcg_pkg::PHASE_BITS-1:0] step;
    logic [dcg_pkg::VALUE_W-1:0]    sat_value;
    logic                           accept;
    logic                           is_tick;
    logic                           in_range;

    assign full = q_full | back_status.clearing;
    assign accept = push & ~full;
    assign is_tick = (command == dcg_pkg::CMD_TICK);
    assign in_range = (32'(table_index) < 32'(dcg_pkg::TABLE_DEPTH));
    assign step = dcg_pkg::PHASE_BITS'(cfg.phase_step);
    assign sat_value = (table_value > dcg_pkg::FULL_SCALE) ? dcg_pkg::FULL_SCALE : table_value;

    // Drop writes beyond the table; they still count as accepted beats.
    assign q_push = accept & (is_tick | in_range);

    always_comb
    begin
        q_item.op = is_tick ? dcg_pkg::OP_TICK : dcg_pkg::OP_WRITE;
        q_item.lock = write_lock;
        if (is_tick)
        begin
            q_item.addr = phase_reg[dcg_pkg::PHASE_BITS-1 -: dcg_pkg::TABLE_ADDR_W];
        end
        else
        begin
            q_item.addr = dcg_pkg::TABLE_ADDR_W'(table_index);
        end
        q_item.data = table_hole ? dcg_pkg::HOLE_WORD : {1'b0, sat_value};
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept && is_tick)
        begin
            case (cfg.direction)
                dcg_pkg::DIR_FORWARD: phase_next = phase_reg + step;
                dcg_pkg::DIR_REVERSE: phase_next = phase_reg - step;
                default:              phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dcg_cmd_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on dcg_pkg.
`default_nettype none

module dcg_cmd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dcg_pkg::cmd_item_t item_in,
    output logic                    full,
    output logic                    valid,
    output dcg_pkg::cmd_item_t      item_out,
    input  wire logic               pop
);

    dcg_pkg::cmd_item_t             slot_reg [dcg_pkg::CMDQ_DEPTH];
    logic [dcg_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [dcg_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [dcg_pkg::CMDQ_CNT_W-1:0] count_reg;
    logic [dcg_pkg::CMDQ_CNT_W-1:0] count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full = (count_reg == dcg_pkg::CMDQ_CNT_W'(dcg_pkg::CMDQ_DEPTH));
    assign valid = (count_reg != '0);
    assign item_out = slot_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop = pop & valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dcg_back.sv -----
// Back end: clears and owns the curve memory, runs the declick ramp and the one-pole
// smoother, and hands finished results to the result queue. Depends on dcg_pkg.
`default_nettype none

module dcg_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dcg_pkg::cfg_t                  cfg,
    output dcg_pkg::back_status_t               status,
    input  wire logic                           q_valid,
    input  wire dcg_pkg::cmd_item_t             q_item,
    output logic                                q_pop,
    input  wire logic [dcg_pkg::RESQ_CNT_W-1:0] res_count,
    output logic                                res_push,
    output dcg_pkg::result_t                    res_item
);

    // Clearing pass and memory
    logic                               clr_active_reg;
    dcg_pkg::addr_t                     clr_addr_reg;
    dcg_pkg::entry_t                    mem [dcg_pkg::TABLE_DEPTH];
    dcg_pkg::entry_t                    rdata_reg;
    logic                               mem_we;
    logic                               mem_re;
    dcg_pkg::addr_t                     mem_addr;
    dcg_pkg::entry_t                    mem_wdata;
    logic [dcg_pkg::RESQ_PEND_W-1:0]    pending;
    logic                               tick_ok;
    logic                               pop_tick;

    // Stage 1: classify the entry, update ramp state, form the ramp product and the smoothing difference
    logic                              s1_valid_reg;
    logic                              s1_lock_reg;
    dcg_pkg::addr_t                    s1_addr_reg;
    logic                              gate_on;
    logic [dcg_pkg::VALUE_W-1:0]       target;
    logic [dcg_pkg::SMOOTH_W-1:0]      goal;
    logic                              gate_edge;
    logic [dcg_pkg::RAMP_W-1:0]        count_eff;
    logic                              rising_eff;
    logic                              prev_eff;
    logic                              prev_gate_reg;
    logic                              ramp_rising_reg;
    logic [dcg_pkg::RAMP_W-1:0]        ramp_count_reg;

    // Stage 2: finish smoothing and form the ROM index
    logic                              s2_valid_reg;
    logic                              s2_active_reg;
    logic                              s2_rising_reg;
    logic                              s2_prev_reg;
    logic [dcg_pkg::USED_W-1:0]        s2_used_reg;
    logic                              s2_up_reg;
    logic [dcg_pkg::SMOOTH_W-1:0]      s2_diff_reg;
    dcg_pkg::addr_t                    s2_addr_reg;
    logic [dcg_pkg::SMOOTH_PROD_W-1:0] smooth_prod;
    logic [dcg_pkg::SMOOTH_W-1:0]      smooth_delta;
    logic [dcg_pkg::SMOOTH_W-1:0]      smoothed_reg;
    logic [dcg_pkg::SMOOTH_W-1:0]      smoothed_next;
    logic [dcg_pkg::PROG_W-1:0]        progress;
    logic [dcg_pkg::RI_PROD_W-1:0]     ri_full;
    logic [dcg_pkg::RI_PROD_W-1:0]     ri_shift;
    logic [dcg_pkg::COS_ADDR_W-1:0]    ri;

    // Stage 3: ROM read, gate select, CV rounding
    logic                              s3_valid_reg;
    logic                              s3_active_reg;
    logic                              s3_rising_reg;
    logic                              s3_prev_reg;
    logic [dcg_pkg::COS_ADDR_W-1:0]    s3_ri_reg;
    dcg_pkg::addr_t                    s3_addr_reg;
    logic [dcg_pkg::VALUE_W-1:0]       env;
    logic [dcg_pkg::CV_SUM_W-1:0]      cv_sum;

    assign status.clearing = clr_active_reg;

    // A tick leaves stage 1 before the next one enters, so the smoother sees its own result.
    assign pending = dcg_pkg::RESQ_PEND_W'(res_count) + dcg_pkg::RESQ_PEND_W'(s1_valid_reg)
                   + dcg_pkg::RESQ_PEND_W'(s2_valid_reg) + dcg_pkg::RESQ_PEND_W'(s3_valid_reg);
    assign tick_ok = ~s1_valid_reg & (pending < dcg_pkg::RESQ_PEND_W'(dcg_pkg::RESQ_DEPTH));
    assign q_pop = q_valid & ~clr_active_reg & ((q_item.op == dcg_pkg::OP_WRITE) | tick_ok);
    assign pop_tick = q_pop & (q_item.op == dcg_pkg::OP_TICK);

    assign mem_we = clr_active_reg | (q_pop & (q_item.op == dcg_pkg::OP_WRITE));
    assign mem_re = pop_tick;
    assign mem_addr = clr_active_reg ? clr_addr_reg : q_item.addr;
    assign mem_wdata = clr_active_reg ? dcg_pkg::HOLE_WORD : q_item.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == dcg_pkg::TABLE_ADDR_W'(dcg_pkg::TABLE_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Stage 1
    always_comb
    begin
        gate_on = ~rdata_reg[dcg_pkg::HOLE_BIT];
        target = gate_on ? rdata_reg[dcg_pkg::VALUE_W-1:0] : '0;
        goal = {target, 8'b0} >> 0;
        gate_edge = ~s1_lock_reg & (gate_on != prev_gate_reg);
        count_eff = gate_edge ? cfg.declick_length : ramp_count_reg;
        rising_eff = gate_edge ? gate_on : ramp_rising_reg;
        prev_eff = gate_edge ? gate_on : prev_gate_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            prev_gate_reg <= 1'b0;
            ramp_rising_reg <= 1'b0;
            ramp_count_reg <= '0;
            smoothed_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= pop_tick;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                prev_gate_reg <= prev_eff;
                ramp_rising_reg <= rising_eff;
                if (count_eff != '0)
                begin
                    ramp_count_reg <= count_eff - 1'b1;
                end
                else
                begin
                    ramp_count_reg <= count_eff;
                end
            end
            if (s2_valid_reg)
            begin
                smoothed_reg <= smoothed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_tick)
        begin
            s1_lock_reg <= q_item.lock;
            s1_addr_reg <= q_item.addr;
        end
        if (s1_valid_reg)
        begin
            s2_active_reg <= (count_eff != '0);
            s2_rising_reg <= rising_eff;
            s2_prev_reg <= prev_eff;
            s2_used_reg <= dcg_pkg::USED_W'(count_eff) * dcg_pkg::USED_W'(cfg.declick_reciprocal);
            s2_up_reg <= (goal >= smoothed_reg);
            s2_diff_reg <= (goal >= smoothed_reg) ? (goal - smoothed_reg) : (smoothed_reg - goal);
            s2_addr_reg <= s1_addr_reg;
        end
        if (s2_valid_reg)
        begin
            s3_active_reg <= s2_active_reg;
            s3_rising_reg <= s2_rising_reg;
            s3_prev_reg <= s2_prev_reg;
            s3_ri_reg <= ri;
            s3_addr_reg <= s2_addr_reg;
        end
    end

    // Stage 2
    always_comb
    begin
        smooth_prod = dcg_pkg::SMOOTH_PROD_W'(cfg.smoothing_coeff)
                    * dcg_pkg::SMOOTH_PROD_W'(s2_diff_reg);
        smooth_delta = dcg_pkg::SMOOTH_W'(smooth_prod >> 16);
        smoothed_next = s2_up_reg ? (smoothed_reg + smooth_delta) : (smoothed_reg - smooth_delta);
        // Saturate progress at zero when the ramp outlasts its length.
        if (s2_used_reg >= dcg_pkg::USED_W'(dcg_pkg::ONE_Q16))
        begin
            progress = '0;
        end
        else
        begin
            progress = dcg_pkg::PROG_W'(dcg_pkg::USED_W'(dcg_pkg::ONE_Q16) - s2_used_reg);
        end
        ri_full = dcg_pkg::RI_PROD_W'(progress) * dcg_pkg::RI_PROD_W'(dcg_pkg::COS_SPAN)
                + dcg_pkg::RI_PROD_W'(32768);
        ri_shift = ri_full >> 16;
        if (ri_shift > dcg_pkg::RI_PROD_W'(dcg_pkg::COS_SPAN))
        begin
            ri = dcg_pkg::COS_ADDR_W'(dcg_pkg::COS_SPAN);
        end
        else
        begin
            ri = dcg_pkg::COS_ADDR_W'(ri_shift);
        end
    end

    // Stage 3
    always_comb
    begin
        env = dcg_pkg::COS_ROM[s3_ri_reg];
        cv_sum = (dcg_pkg::CV_SUM_W'(smoothed_reg) + dcg_pkg::CV_SUM_W'(128)) >> 8;
        res_push = s3_valid_reg;
        res_item.cv = dcg_pkg::VALUE_W'(cv_sum);
        if (s3_active_reg)
        begin
            res_item.gate = s3_rising_reg ? env : (dcg_pkg::FULL_SCALE - env);
        end
        else
        begin
            res_item.gate = s3_prev_reg ? dcg_pkg::FULL_SCALE : '0;
        end
        res_item.scan_index = dcg_pkg::INDEX_W'(s3_addr_reg);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dcg_result_queue.sv -----
// Result queue on the output side; its head drives the result ports.
// Depends on dcg_pkg.
`default_nettype none

module dcg_result_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire dcg_pkg::result_t              item_in,
    output logic [dcg_pkg::RESQ_CNT_W-1:0]     count,
    output logic                               empty,
    output dcg_pkg::result_t                   head,
    input  wire logic                          pop
);

    dcg_pkg::result_t               slot_reg [dcg_pkg::RESQ_DEPTH];
    logic [dcg_pkg::RESQ_PTR_W-1:0] wr_ptr_reg;
    logic [dcg_pkg::RESQ_PTR_W-1:0] rd_ptr_reg;
    logic [dcg_pkg::RESQ_CNT_W-1:0] count_reg;
    logic [dcg_pkg::RESQ_CNT_W-1:0] count_next;
    logic                           do_pop;

    // The back end never pushes without a free slot, so push needs no guard.
    assign count = count_reg;
    assign empty = (count_reg == '0);
    assign head = slot_reg[rd_ptr_reg];
    assign do_pop = pop & ~empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench of drawn_curve_cv_gate_generator: curve writes and ticks, directed then random,
// with every tick result checked field by field against a predictor kept in this file.
// Depends on dcg_pkg and the RTL under hw/rtl; reads no files.
module tb;
    import dcg_pkg::*;

    localparam logic [63:0] Q28_ONE = 64'd268435456;
    localparam logic [63:0] Q28_PI = 64'd843314857;
    localparam logic [DIR_W-1:0] DIR_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [STEP_W-1:0] ONE_ENTRY_STEP = 32'h0020_0000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        op_t                op;
        logic               lock;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               hole;
    } curve_beat_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic                   command;
    logic                   write_lock;
    logic [INDEX_W-1:0]     table_index;
    logic [VALUE_W-1:0]     table_value;
    logic                   table_hole;
    logic                   empty;
    logic                   pop;
    logic [VALUE_W-1:0]     cv;
    logic [VALUE_W-1:0]     gate;
    logic [INDEX_W-1:0]     scan_index;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state
    logic [STEP_W-1:0]  pred_phase;
    entry_t             curve_mirror [TABLE_DEPTH];
    logic               gate_held;
    logic               ramp_up;
    int                 ramp_left;
    logic [31:0]        smooth_acc;
    logic [STEP_W-1:0]  reg_step;
    logic [DIR_W-1:0]   reg_dir;
    logic [RAMP_W-1:0]  reg_len;
    logic [RECIP_W-1:0] reg_recip;
    logic [COEFF_W-1:0] reg_coeff;
    logic [VALUE_W-1:0] ramp_rom [COS_DEPTH];

    result_t expected_samples [$];
    result_t want;
    int      fault_count;
    bit      steady;
    int      hold_request = 0;
    logic    sink_hold;

    drawn_curve_cv_gate_generator uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void reset_predictor();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        // raised-cosine ramp, Taylor series of cos in Q28
        for (int k = 0; k < COS_DEPTH; k++)
        begin
            x = (Q28_PI * 64'(k) + 64'(COS_SPAN / 2)) / 64'(COS_SPAN);
            x2 = (x * x) >> 28;
            term = Q28_ONE;
            sum = longint'(Q28_ONE);
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            v = (longint'(Q28_ONE) - sum + 64'sd8192) / 64'sd16384;
            if (v < 0)
                v = 0;
            if (v > 32768)
                v = 32768;
            ramp_rom[k] = VALUE_W'(v);
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            curve_mirror[i] = HOLE_WORD;
        pred_phase = '0;
        gate_held = 1'b0;
        ramp_up = 1'b0;
        ramp_left = 0;
        smooth_acc = '0;
        reg_step = RST_PHASE_STEP;
        reg_dir = RST_DIRECTION;
        reg_len = RST_DECLICK_LENGTH;
        reg_recip = RST_DECLICK_RECIP;
        reg_coeff = RST_SMOOTHING_COEFF;
    endfunction

    function automatic void advance_generator(input curve_beat_t b);
        logic [INDEX_W-1:0] idx;
        entry_t             e;
        logic               on;
        logic [VALUE_W-1:0] target;
        logic [VALUE_W-1:0] gate_out;
        logic [63:0]        used;
        logic [63:0]        progress;
        logic [63:0]        ri;
        logic [31:0]        goal;
        logic [31:0]        rounded;
        result_t            r;
        if (b.op == OP_WRITE)
        begin
            if (b.hole)
                curve_mirror[b.index] = HOLE_WORD;
            else if (b.value > FULL_SCALE)
                curve_mirror[b.index] = {1'b0, FULL_SCALE};
            else
                curve_mirror[b.index] = {1'b0, b.value};
            return;
        end
        idx = pred_phase[PHASE_BITS-1 -: INDEX_W];
        e = curve_mirror[idx];
        on = !e[HOLE_BIT];
        target = on ? e[VALUE_W-1:0] : '0;
        if (!b.lock && on != gate_held)
        begin
            ramp_up = on;
            ramp_left = reg_len;
            gate_held = on;
        end
        if (ramp_left > 0)
        begin
            used = 64'(ramp_left) * 64'(reg_recip);
            progress = (used >= 64'(ONE_Q16)) ? 64'd0 : 64'(ONE_Q16) - used;
            ri = (progress * 64'(COS_SPAN) + 64'd32768) >> 16;
            if (ri > 64'(COS_SPAN))
                ri = 64'(COS_SPAN);
            gate_out = ramp_up ? ramp_rom[ri[COS_ADDR_W-1:0]]
                               : FULL_SCALE - ramp_rom[ri[COS_ADDR_W-1:0]];
            ramp_left--;
        end
        else
        begin
            gate_out = gate_held ? FULL_SCALE : '0;
        end
        // one-pole step toward the target, truncated toward zero
        goal = 32'(target) << 8;
        if (goal >= smooth_acc)
            smooth_acc = smooth_acc + 32'((64'(reg_coeff) * 64'(goal - smooth_acc)) >> 16);
        else
            smooth_acc = smooth_acc - 32'((64'(reg_coeff) * 64'(smooth_acc - goal)) >> 16);
        rounded = smooth_acc + 32'd128;
        r.cv = rounded[23:8];
        r.gate = gate_out;
        r.scan_index = idx;
        expected_samples = {expected_samples, r};
        case (reg_dir)
            DIR_FORWARD: pred_phase = pred_phase + reg_step;
            DIR_REVERSE: pred_phase = pred_phase - reg_step;
            default:     pred_phase = pred_phase;
        endcase
    endfunction

    function automatic curve_beat_t write_beat(input int index, input int value,
                                               input logic hole);
        curve_beat_t b;
        b.op = OP_WRITE;
        b.lock = 1'($urandom);
        b.index = INDEX_W'(index);
        b.value = VALUE_W'(value);
        b.hole = hole;
        return b;
    endfunction

    function automatic curve_beat_t tick_beat(input logic lock);
        curve_beat_t b;
        b.op = OP_TICK;
        b.lock = lock;
        b.index = INDEX_W'($urandom);
        b.value = VALUE_W'($urandom);
        b.hole = 1'($urandom);
        return b;
    endfunction

    function automatic curve_beat_t random_beat();
        int index;
        int value;
        int pick;
        if ($urandom_range(99) >= 35)
            return tick_beat($urandom_range(99) < 15);
        // aim half of the writes at the entries around the scan position
        pick = $urandom_range(9);
        if (pick < 5)
            index = int'(pred_phase[PHASE_BITS-1 -: INDEX_W]) + $urandom_range(12) - 6;
        else if (pick == 5)
            index = $urandom_range(1) ? TABLE_DEPTH - 1 : 0;
        else
            index = $urandom_range(TABLE_DEPTH - 1);
        pick = $urandom_range(19);
        case (pick)
            0:       value = 0;
            1:       value = FULL_SCALE - 1;
            2:       value = FULL_SCALE;
            3:       value = FULL_SCALE + 1;
            4:       value = 65535;
            5, 6, 7, 8, 9, 10, 11, 12:
                     value = $urandom_range(FULL_SCALE);
            default: value = $urandom_range(65535);
        endcase
        return write_beat(index, value, $urandom_range(99) < 35);
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v,
                     $time);
    endtask

    task automatic send_beat(input curve_beat_t b);
        while (!steady && $urandom_range(99) < 8)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        command <= b.op;
        write_lock <= b.lock;
        table_index <= b.index;
        table_value <= b.value;
        table_hole <= b.hole;
        @(posedge clk);
        while (full)
            @(posedge clk);
        advance_generator(b);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_beat(random_beat());
    endtask

    // Drop push, wait for every pending result, then let trailing writes finish.
    task automatic settle();
        push <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_PHASE_STEP:      reg_step = data;
            CFG_DIRECTION:       reg_dir = data[DIR_W-1:0];
            CFG_DECLICK_LENGTH:  reg_len = data[RAMP_W-1:0];
            CFG_DECLICK_RECIP:   reg_recip = data[RECIP_W-1:0];
            CFG_SMOOTHING_COEFF: reg_coeff = data[COEFF_W-1:0];
            default:             reg_step = reg_step;
        endcase
    endtask

    // Fill the bits above a register's width with noise; the block must drop them.
    function automatic logic [31:0] pad_bits(input logic [31:0] value, input int width);
        return ($urandom() << width) | value;
    endfunction

    task automatic set_config(input logic [31:0] step, input logic [DIR_W-1:0] dir,
                              input int len, input int recip, input int coeff);
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_DIRECTION, pad_bits(32'(dir), DIR_W));
        write_reg(CFG_DECLICK_LENGTH, pad_bits(32'(len), RAMP_W));
        write_reg(CFG_DECLICK_RECIP, pad_bits(32'(recip), RECIP_W));
        write_reg(CFG_SMOOTHING_COEFF, pad_bits(32'(coeff), COEFF_W));
        cfg_write <= 1'b0;
    endtask

    task automatic test_entry_writes_and_scan();
        send_beat(write_beat(0, 0, 1'b0));
        send_beat(write_beat(1, 65535, 1'b0));
        send_beat(write_beat(2, 16'h1234, 1'b1));
        send_beat(write_beat(3, FULL_SCALE + 1, 1'b0));
        send_beat(write_beat(4, FULL_SCALE - 1, 1'b0));
        send_beat(write_beat(TABLE_DEPTH - 1, FULL_SCALE, 1'b0));
        // two ticks on the reset settings
        send_beat(tick_beat(1'b0));
        send_beat(tick_beat(1'b1));
        settle();
        // ramp length times reciprocal lands exactly on one: progress saturates
        set_config(ONE_ENTRY_STEP, DIR_FORWARD, 2, 32768, 65535);
        send_beat(tick_beat(1'b0));
        send_beat(tick_beat(1'b0));
        send_beat(tick_beat(1'b1));
        send_beat(tick_beat(1'b0));
        send_beat(tick_beat(1'b0));
    endtask

    // Reverse through entry zero into the top of the table, gate switching at once.
    task automatic test_reverse_wrap();
        settle();
        set_config(ONE_ENTRY_STEP, DIR_REVERSE, 0, 0, 32768);
        repeat (7)
            send_beat(tick_beat(1'b0));
    endtask

    task automatic test_frozen_phase();
        settle();
        write_reg(CFG_SPARE, '1);
        set_config(32'hFFFF_FFFF, DIR_UNUSED, 4095, 131071, 0);
        send_beat(write_beat(TABLE_DEPTH - 2, 100, 1'b0));
        repeat (3)
            send_beat(tick_beat(1'b0));
    endtask

    task automatic test_random_curves();
        int len;
        settle();
        set_config(ONE_ENTRY_STEP, DIR_FORWARD, 8, 8192, 65535);
        steady = 1'b1;
        send_random(90);
        steady = 1'b0;
        settle();
        set_config(32'hFFFF_FFFF, DIR_REVERSE, 4095, 16, 0);
        send_random(40);
        settle();
        set_config($urandom, DIR_UNUSED, 0, 0, 32768);
        send_random(60);
        settle();
        len = $urandom_range(40, 1);
        set_config($urandom, DIR_REVERSE, len, ONE_Q16 / len, $urandom_range(65535));
        send_random(90);
        settle();
        // ramp longer than its length: progress saturates for the first ticks
        set_config(ONE_ENTRY_STEP * $urandom_range(7, 1) + $urandom_range(65535),
                   DIR_FORWARD, 64, 4096, $urandom_range(65535));
        send_random(90);
        settle();
        set_config(0, DIR_FROZEN, 3, 131071, 65535);
        send_random(40);
        settle();
        set_config(ONE_ENTRY_STEP >> $urandom_range(4), DIR_FORWARD, $urandom_range(4095),
                   $urandom_range(131071), $urandom_range(65535));
        send_random(100);
    endtask

    // Hold results back long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        settle();
        set_config(ONE_ENTRY_STEP, DIR_FORWARD, 16, 4096, 4000);
        hold_request = HOLD_CYCLES;
        send_random(40);
        settle();
    endtask

    initial
    begin
        sink_hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                sink_hold <= 1'b1;
                repeat (hold_request) @(posedge clk);
                sink_hold <= 1'b0;
                hold_request = 0;
            end
        end
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            pop <= !sink_hold && (steady || $urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch("result with nothing pending", -1, cv);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (cv !== want.cv)
                    report_mismatch("cv", want.cv, cv);
                if (gate !== want.gate)
                    report_mismatch("gate", want.gate, gate);
                if (scan_index !== want.scan_index)
                    report_mismatch("scan_index", want.scan_index, scan_index);
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        command = CMD_TICK;
        write_lock = 1'b0;
        table_index = '0;
        table_value = '0;
        table_hole = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_PHASE_STEP;
        cfg_data = '0;
        steady = 1'b0;
        fault_count = 0;
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_entry_writes_and_scan();
        test_reverse_wrap();
        test_frozen_phase();
        test_random_curves();
        test_output_backpressure();
        settle();
        if (fault_count == 0 && expected_samples.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
